// File: hdl/bis_pkg.sv
package bis_pkg;

   // Fixed field widths of the channels and the configuration port.
   localparam int POS_W      = 12;
   localparam int COLOR_W    = 8;
   localparam int RGB_W      = 24;
   localparam int FRAC_W     = 16;
   localparam int SRC_REG_W  = 9;
   localparam int DST_REG_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int UV_W       = 8;
   localparam int WGT_W      = 17;
   localparam int PROD_W     = WGT_W + COLOR_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int CALC_W     = 16;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [WGT_W-1:0]    ONE_WEIGHT    = 17'h10000;
   localparam logic [SRC_REG_W-1:0] SRC_RESET    = 9'd256;
   localparam logic [DST_REG_W-1:0] DST_RESET    = 13'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_FETCH = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_FETCH = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [RGB_W-1:0]   rgb;
   } item_type;

endpackage

// File: hdl/bis_if.sv
// Request channel: pixel writes and scaled pixel fetches.
interface bis_req_if import bis_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [POS_W-1:0]     pos_x;
   logic [POS_W-1:0]     pos_y;
   logic [COLOR_W-1:0]   in_red;
   logic [COLOR_W-1:0]   in_green;
   logic [COLOR_W-1:0]   in_blue;

   modport source (output valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                   input ready);
   modport sink (input valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                 output ready);
endinterface

// Response channel: one interpolated pixel per fetch.
interface bis_rsp_if import bis_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COLOR_W-1:0]   out_red;
   logic [COLOR_W-1:0]   out_green;
   logic [COLOR_W-1:0]   out_blue;
   logic                 coord_error;

   modport source (output valid, out_red, out_green, out_blue, coord_error,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, coord_error,
                 output ready);
endinterface

// File: hdl/bis_step_div.sv
module bis_step_div import bis_pkg::*; #(
   parameter int DVD_W = 24,
   parameter int DVS_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] work_ff, work_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, work_ff[DVD_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[DVD_W-2:0], fits};
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = work_ff;

   // The last step of a run must end the run unless a new one starts.
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1) && !start) |=> !busy_ff)
      else $error("divider kept running past its last step");

endmodule

// File: hdl/bis_front.sv
module bis_front import bis_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_DIM    = 4096,
   localparam int XS_W = $clog2(MAX_SRC_WIDTH),
   localparam int YS_W = $clog2(MAX_SRC_HEIGHT),
   localparam int XD_W = XS_W + FRAC_W,
   localparam int YD_W = YS_W + FRAC_W
) (
   input  logic                  clock,
   input  logic                  reset,
   bis_req_if.sink               req_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  push,
   output item_type              push_item,
   input  logic                  queue_full,
   output logic [XS_W-1:0]       last_x,
   output logic [YS_W-1:0]       last_y,
   output logic [XD_W-1:0]       step_x,
   output logic [YD_W-1:0]       step_y
);

   localparam int DW_W = $clog2(MAX_DST_DIM + 1);
   localparam logic [CALC_W-1:0] MAX_W16 = CALC_W'(MAX_SRC_WIDTH);
   localparam logic [CALC_W-1:0] MAX_H16 = CALC_W'(MAX_SRC_HEIGHT);
   localparam logic [CALC_W-1:0] MAX_D16 = CALC_W'(MAX_DST_DIM);

   logic [SRC_REG_W-1:0] src_w_ff, src_h_ff;
   logic [DST_REG_W-1:0] dst_w_ff, dst_h_ff;
   logic                 start_ff;
   logic [CALC_W-1:0]    sw16, sh16, dw16, dh16;
   logic [CALC_W-1:0]    sw_cl, sh_cl, dw_cl, dh_cl;
   logic                 busy_x, busy_y;
   logic [XD_W-1:0]      quot_x;
   logic [YD_W-1:0]      quot_y;
   logic                 accept;
   logic                 is_fetch;
   logic                 out_of_dst;
   logic                 in_store;

   // Configuration registers; every write restarts the step calculation.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_RESET;
         src_h_ff <= SRC_RESET;
         dst_w_ff <= DST_RESET;
         dst_h_ff <= DST_RESET;
         start_ff <= 1'b1;
      end else begin
         start_ff <= csr_we;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SRC_REG_W-1:0];
               CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SRC_REG_W-1:0];
               CSR_DST_WIDTH:  dst_w_ff <= csr_wdata;
               CSR_DST_HEIGHT: dst_h_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Sizes as used: a zero source is one pixel, and all are capped at the maxima.
   always_comb begin
      sw16  = CALC_W'(src_w_ff);
      sh16  = CALC_W'(src_h_ff);
      dw16  = CALC_W'(dst_w_ff);
      dh16  = CALC_W'(dst_h_ff);
      sw_cl = (sw16 == '0) ? CALC_W'(1) : ((sw16 > MAX_W16) ? MAX_W16 : sw16);
      sh_cl = (sh16 == '0) ? CALC_W'(1) : ((sh16 > MAX_H16) ? MAX_H16 : sh16);
      dw_cl = (dw16 > MAX_D16) ? MAX_D16 : dw16;
      dh_cl = (dh16 > MAX_D16) ? MAX_D16 : dh16;
   end

   assign last_x = XS_W'(sw_cl - 1'b1);
   assign last_y = YS_W'(sh_cl - 1'b1);

   // Step per axis: ((src - 1) << 16) / dst + 1, one quotient bit a cycle.
   bis_step_div #(.DVD_W(XD_W), .DVS_W(DW_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ({last_x, FRAC_W'(0)}),
      .divisor  (DW_W'(dw_cl)),
      .busy     (busy_x),
      .quotient (quot_x)
   );

   bis_step_div #(.DVD_W(YD_W), .DVS_W(DW_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ({last_y, FRAC_W'(0)}),
      .divisor  (DW_W'(dh_cl)),
      .busy     (busy_y),
      .quotient (quot_y)
   );

   assign step_x = quot_x + 1'b1;
   assign step_y = quot_y + 1'b1;

   // Classify each item; writes outside the storage are taken and dropped.
   assign req_chan.ready = !start_ff && !busy_x && !busy_y && !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_fetch       = (action_type'(req_chan.action) == ACT_FETCH);

   always_comb begin
      out_of_dst = (CALC_W'(req_chan.pos_x) >= dw_cl) ||
                   (CALC_W'(req_chan.pos_y) >= dh_cl);
      in_store   = (CALC_W'(req_chan.pos_x) < MAX_W16) &&
                   (CALC_W'(req_chan.pos_y) < MAX_H16);
      push_item.pos_x = req_chan.pos_x;
      push_item.pos_y = req_chan.pos_y;
      push_item.rgb   = {req_chan.in_red, req_chan.in_green, req_chan.in_blue};
      if (!is_fetch) begin
         push_item.kind = KIND_WRITE;
      end else if (out_of_dst) begin
         push_item.kind = KIND_ERROR;
      end else begin
         push_item.kind = KIND_FETCH;
      end
      push = accept && (is_fetch || in_store);
   end

   // No item may enter while a step is being recalculated.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start_ff || busy_x || busy_y) |-> !req_chan.ready)
      else $error("item accepted while step calculation runs");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> (busy_x && busy_y))
      else $error("step calculation did not start");

endmodule

// File: hdl/bis_queue.sv
module bis_queue import bis_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head_item,
   output logic     not_empty
);

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head_item = slot_ff[rd_ptr_ff];

   // Small ring buffer that lets front and back stall on their own.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("item pushed into a full queue");

endmodule

// File: hdl/bis_back.sv
module bis_back import bis_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   localparam int XS_W = $clog2(MAX_SRC_WIDTH),
   localparam int YS_W = $clog2(MAX_SRC_HEIGHT),
   localparam int XD_W = XS_W + FRAC_W,
   localparam int YD_W = YS_W + FRAC_W
) (
   input  logic            clock,
   input  logic            reset,
   input  item_type        head_item,
   input  logic            head_valid,
   output logic            pop,
   input  logic [XS_W-1:0] last_x,
   input  logic [YS_W-1:0] last_y,
   input  logic [XD_W-1:0] step_x,
   input  logic [YD_W-1:0] step_y,
   bis_rsp_if.source       rsp_chan
);

   localparam int PX_W   = POS_W + XD_W;
   localparam int PY_W   = POS_W + YD_W;
   localparam int IX_W   = PX_W - FRAC_W;
   localparam int IY_W   = PY_W - FRAC_W;
   localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int NBANK  = 4;

   // Address inside a bank: the banks split the frame by column and row parity.
   function automatic logic [BANK_AW-1:0] bank_addr(input logic [XS_W-1:0] col,
                                                   input logic [YS_W-1:0] row);
      logic [31:0] full_addr;
      full_addr = 32'(row >> 1) * 32'(HALF_W) + 32'(col >> 1);
      return BANK_AW'(full_addr);
   endfunction

   logic adv;

   // Stage 1: source positions in fixed point with 16 fraction bits (20.16 at the defaults).
   logic            s1_valid_ff;
   item_type        s1_item_ff;
   logic [PX_W-1:0] s1_px_ff;
   logic [PY_W-1:0] s1_py_ff;

   // Stage 2: neighbour indices, memory access, corner weight.
   logic [IX_W-1:0]    ipx;
   logic [IY_W-1:0]    ipy;
   logic [XS_W-1:0]    x0, x1;
   logic [YS_W-1:0]    y0, y1;
   logic [UV_W-1:0]    u, v;
   logic [BANK_AW-1:0] rd_addr [NBANK];
   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;
   logic               wr_en;
   logic [RGB_W-1:0]   mem_q [NBANK][BANK_DEPTH];
   logic [RGB_W-1:0]   rd_ff [NBANK];

   logic                  s3_valid_ff;
   kind_type              s3_kind_ff;
   logic                  s3_x0p_ff, s3_x1p_ff, s3_y0p_ff, s3_y1p_ff;
   logic [UV_W-1:0]       s3_u_ff, s3_v_ff;
   logic [2*UV_W-1:0]     s3_w11_ff;

   // Stage 3 and 4: weights and pixels, then products.
   logic [WGT_W-1:0]  w_in [NBANK];
   logic [RGB_W-1:0]  c_in [NBANK];
   logic [2*UV_W-1:0] w10_n, w01_n;

   logic              s4_valid_ff;
   kind_type          s4_kind_ff;
   logic [WGT_W-1:0]  s4_w_ff [NBANK];
   logic [RGB_W-1:0]  s4_c_ff [NBANK];

   logic              s5_valid_ff;
   kind_type          s5_kind_ff;
   logic [PROD_W-1:0] s5_prod_ff [3][NBANK];
   logic [SUM_W-1:0]  sum_n [3];

   logic               rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic               rsp_err_ff;

   // The whole pipeline moves while the output register can take a result.
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign pop = adv;

   // Stage 1: multiply the coordinates by the steps.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= head_valid;
      end
      if (adv) begin
         s1_item_ff <= head_item;
         s1_px_ff   <= PX_W'(head_item.pos_x) * PX_W'(step_x);
         s1_py_ff   <= PY_W'(head_item.pos_y) * PY_W'(step_y);
      end
   end

   // Stage 2: clamp neighbours to the last column and row, pick bank addresses.
   always_comb begin
      ipx = s1_px_ff[PX_W-1:FRAC_W];
      ipy = s1_py_ff[PY_W-1:FRAC_W];
      x0  = (ipx > IX_W'(last_x)) ? last_x : ipx[XS_W-1:0];
      y0  = (ipy > IY_W'(last_y)) ? last_y : ipy[YS_W-1:0];
      x1  = (x0 == last_x) ? x0 : XS_W'(x0 + 1'b1);
      y1  = (y0 == last_y) ? y0 : YS_W'(y0 + 1'b1);
      u   = s1_px_ff[FRAC_W-1:FRAC_W-UV_W];
      v   = s1_py_ff[FRAC_W-1:FRAC_W-UV_W];
      for (int b = 0; b < NBANK; b++) begin
         rd_addr[b] = bank_addr((x0[0] == b[0]) ? x0 : x1,
                                (y0[0] == b[1]) ? y0 : y1);
      end
      wr_addr = bank_addr(s1_item_ff.pos_x[XS_W-1:0], s1_item_ff.pos_y[YS_W-1:0]);
      wr_bank = {s1_item_ff.pos_y[0], s1_item_ff.pos_x[0]};
      wr_en   = adv && s1_valid_ff && (s1_item_ff.kind == KIND_WRITE);
   end

   // Frame store: four parity banks, one write and one read port each.
   always_ff @(posedge clock) begin
      for (int b = 0; b < NBANK; b++) begin
         if (wr_en && (wr_bank == 2'(b))) begin
            mem_q[b][wr_addr] <= s1_item_ff.rgb;
         end
         if (adv) begin
            rd_ff[b] <= mem_q[b][rd_addr[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s3_kind_ff <= s1_item_ff.kind;
         s3_x0p_ff  <= x0[0];
         s3_x1p_ff  <= x1[0];
         s3_y0p_ff  <= y0[0];
         s3_y1p_ff  <= y1[0];
         s3_u_ff    <= u;
         s3_v_ff    <= v;
         s3_w11_ff  <= u * v;
      end
   end

   // Stage 3: the four weights sum to one, and each corner reads its bank.
   always_comb begin
      w10_n   = {s3_u_ff, UV_W'(0)} - s3_w11_ff;
      w01_n   = {s3_v_ff, UV_W'(0)} - s3_w11_ff;
      w_in[1] = WGT_W'(w10_n);
      w_in[2] = WGT_W'(w01_n);
      w_in[3] = WGT_W'(s3_w11_ff);
      w_in[0] = ONE_WEIGHT - w_in[2] - w_in[1] - w_in[3];
      c_in[0] = rd_ff[{s3_y0p_ff, s3_x0p_ff}];
      c_in[1] = rd_ff[{s3_y0p_ff, s3_x1p_ff}];
      c_in[2] = rd_ff[{s3_y1p_ff, s3_x0p_ff}];
      c_in[3] = rd_ff[{s3_y1p_ff, s3_x1p_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_kind_ff <= s3_kind_ff;
         s4_w_ff    <= w_in;
         s4_c_ff    <= c_in;
      end
   end

   // Stage 4: weight each colour of each corner.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (adv) begin
         s5_kind_ff <= s4_kind_ff;
         for (int k = 0; k < 3; k++) begin
            for (int n = 0; n < NBANK; n++) begin
               s5_prod_ff[k][n] <= PROD_W'(s4_w_ff[n]) *
                  PROD_W'(s4_c_ff[n][RGB_W-1-COLOR_W*k -: COLOR_W]);
            end
         end
      end
   end

   // Stage 5: sum the corners and drop the fraction.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_n[k] = SUM_W'(s5_prod_ff[k][0]) + SUM_W'(s5_prod_ff[k][1]) +
                    SUM_W'(s5_prod_ff[k][2]) + SUM_W'(s5_prod_ff[k][3]);
      end
   end

   // Output register; writes leave no result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s5_valid_ff && (s5_kind_ff != KIND_WRITE);
      end
      if (adv) begin
         rsp_err_ff <= (s5_kind_ff == KIND_ERROR);
         if (s5_kind_ff == KIND_ERROR) begin
            rsp_red_ff   <= '0;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
         end else begin
            rsp_red_ff   <= sum_n[0][FRAC_W +: COLOR_W];
            rsp_green_ff <= sum_n[1][FRAC_W +: COLOR_W];
            rsp_blue_ff  <= sum_n[2][FRAC_W +: COLOR_W];
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_red     = rsp_red_ff;
   assign rsp_chan.out_green   = rsp_green_ff;
   assign rsp_chan.out_blue    = rsp_blue_ff;
   assign rsp_chan.coord_error = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |->
         (rsp_red_ff == '0 && rsp_green_ff == '0 && rsp_blue_ff == '0))
      else $error("error result carries a colour");

endmodule

// File: hdl/bilinear_image_scaler_top.sv
// Bilinear image scaler.
// req_chan carries items: action 0 stores one source pixel at (pos_x, pos_y),
// action 1 fetches the scaled pixel at destination (pos_x, pos_y). Only a
// fetch gives an item on rsp_chan: the interpolated colour, or zero colour
// with coord_error set when the coordinate is outside the destination size.
// The csr port writes source and destination sizes; write them while idle.
// Throughput is one item per cycle in both directions while nothing stalls it
// (receiver, full queue, step calculation). A fetch is written into the queue
// at its accepting edge, then goes through the position multiply, the frame
// store read, the weights and the products to the output register and rsp_chan.
// After reset and after every csr write the per-axis steps are worked out by
// a serial divider, one quotient bit a cycle; req_chan.ready stays low until
// the dividers of both axes are done.
// When the receiver stalls, the result holds in the output register, the
// pipeline stops, the four-item queue fills and then req_chan.ready drops.
// The frame store holds no defined data after reset: fetch only what was written.
module bilinear_image_scaler_top import bis_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_DIM    = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   bis_req_if.sink               req_chan,
   bis_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XS_W = $clog2(MAX_SRC_WIDTH);
   localparam int YS_W = $clog2(MAX_SRC_HEIGHT);
   localparam int XD_W = XS_W + FRAC_W;
   localparam int YD_W = YS_W + FRAC_W;

   logic            push;
   item_type        push_item;
   logic            queue_full;
   logic            pop;
   item_type        head_item;
   logic            head_valid;
   logic [XS_W-1:0] last_x;
   logic [YS_W-1:0] last_y;
   logic [XD_W-1:0] step_x;
   logic [YD_W-1:0] step_y;

   bis_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .MAX_DST_DIM    (MAX_DST_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full),
      .last_x     (last_x),
      .last_y     (last_y),
      .step_x     (step_x),
      .step_y     (step_y)
   );

   bis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (head_valid)
   );

   bis_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .pop        (pop),
      .last_x     (last_x),
      .last_y     (last_y),
      .step_x     (step_x),
      .step_y     (step_y),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: tb/scaler_checker.sv
// Watches the request, result and register ports of the scaler, predicts every
// scaled pixel and compares it with what the block returns.
module scaler_checker import bis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bis_req_if                    req,
   bis_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_DIM = 256;
   localparam int DST_MAX   = 4096;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               coord_error;
   } scaled_pixel_type;

   logic [RGB_W-1:0]     frame_mirror [FRAME_DIM*FRAME_DIM];
   logic [SRC_REG_W-1:0] src_w_reg, src_h_reg;
   logic [DST_REG_W-1:0] dst_w_reg, dst_h_reg;
   scaled_pixel_type     pixel_q [$];

   // Source index pair and 8-bit fraction along one axis.
   function automatic void locate_axis(input int unsigned d, input int unsigned s,
                                       input int unsigned dd, output int unsigned i0,
                                       output int unsigned i1, output int unsigned f8);
      longint unsigned step;
      longint unsigned p;
      longint unsigned ip;
      int unsigned     last;
      step = (64'(s - 1) << 16) / 64'(dd) + 1;
      p    = 64'(d) * step;
      ip   = p >> 16;
      last = s - 1;
      i0   = (ip > 64'(last)) ? last : int'(ip);
      i1   = (i0 + 1 > last) ? last : i0 + 1;
      f8   = int'((p & 64'hFFFF) >> 8);
   endfunction

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic scaled_pixel_type scale_pixel(input int unsigned px,
                                                    input int unsigned py);
      scaled_pixel_type res;
      int unsigned     sw, sh, dw, dh, x0, x1, y0, y1, u, v;
      int unsigned     w00, w01, w10, w11;
      logic [RGB_W-1:0] c00, c10, c01, c11;
      longint unsigned acc;
      sw = clamp_size(src_w_reg, FRAME_DIM);
      sh = clamp_size(src_h_reg, FRAME_DIM);
      dw = (dst_w_reg > DST_MAX) ? DST_MAX : dst_w_reg;
      dh = (dst_h_reg > DST_MAX) ? DST_MAX : dst_h_reg;
      res = '0;
      if (px >= dw || py >= dh) begin
         res.coord_error = 1'b1;
         return res;
      end
      locate_axis(px, sw, dw, x0, x1, u);
      locate_axis(py, sh, dh, y0, y1, v);
      w11 = u * v;
      w10 = (u << 8) - w11;
      w01 = (v << 8) - w11;
      w00 = 65536 - w01 - w10 - w11;
      c00 = frame_mirror[y0*FRAME_DIM + x0];
      c10 = frame_mirror[y0*FRAME_DIM + x1];
      c01 = frame_mirror[y1*FRAME_DIM + x0];
      c11 = frame_mirror[y1*FRAME_DIM + x1];
      for (int k = 0; k < 3; k++) begin
         acc = 64'(w00) * c00[16-8*k +: 8] + 64'(w10) * c10[16-8*k +: 8]
             + 64'(w01) * c01[16-8*k +: 8] + 64'(w11) * c11[16-8*k +: 8];
         case (k)
            0: res.red   = acc[23:16];
            1: res.green = acc[23:16];
            default: res.blue = acc[23:16];
         endcase
      end
      return res;
   endfunction

   // Compare returned pixels, then track register writes and accepted items.
   always @(posedge clock) begin
      scaled_pixel_type want;
      if (reset) begin
         src_w_reg = SRC_RESET;
         src_h_reg = SRC_RESET;
         dst_w_reg = DST_RESET;
         dst_h_reg = DST_RESET;
         pixel_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pixel_q.size() == 0) begin
               $error("result item with no fetch waiting");
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp.out_red !== want.red || rsp.out_green !== want.green ||
                   rsp.out_blue !== want.blue || rsp.coord_error !== want.coord_error)
                  fail_count <= fail_count + 1;
               if (rsp.out_red !== want.red)
                  $error("out_red expected %0d got %0d", want.red, rsp.out_red);
               if (rsp.out_green !== want.green)
                  $error("out_green expected %0d got %0d", want.green, rsp.out_green);
               if (rsp.out_blue !== want.blue)
                  $error("out_blue expected %0d got %0d", want.blue, rsp.out_blue);
               if (rsp.coord_error !== want.coord_error)
                  $error("coord_error expected %0d got %0d", want.coord_error,
                         rsp.coord_error);
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SRC_WIDTH:  src_w_reg = csr_wdata[SRC_REG_W-1:0];
               CSR_SRC_HEIGHT: src_h_reg = csr_wdata[SRC_REG_W-1:0];
               CSR_DST_WIDTH:  dst_w_reg = csr_wdata;
               CSR_DST_HEIGHT: dst_h_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (action_type'(req.action) == ACT_FETCH)
               pixel_q.push_back(scale_pixel(req.pos_x, req.pos_y));
            else if (req.pos_x < FRAME_DIM && req.pos_y < FRAME_DIM)
               frame_mirror[req.pos_y*FRAME_DIM + req.pos_x] =
                  {req.in_red, req.in_green, req.in_blue};
         end
      end
      outstanding <= pixel_q.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   import bis_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   int                    item_count;
   int                    send_idle_pct;
   int                    recv_stall_pct;

   bis_req_if req ();
   bis_rsp_if rsp ();

   bilinear_image_scaler_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scaler_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Send one item, idling first at random, and wait until it is accepted.
   task automatic send_item(input action_type act, input int unsigned x,
                            input int unsigned y, input int unsigned rgb);
      if (item_count < 420) begin
         send_idle_pct  = 21;
         recv_stall_pct = 49;
      end else if (item_count < 840) begin
         send_idle_pct  = 49;
         recv_stall_pct = 21;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid    <= 1'b1;
      req.action   <= act;
      req.pos_x    <= x[POS_W-1:0];
      req.pos_y    <= y[POS_W-1:0];
      req.in_red   <= rgb[23:16];
      req.in_green <= rgb[15:8];
      req.in_blue  <= rgb[7:0];
      do @(posedge clock); while (!req.ready);
      item_count++;
   endtask

   // Hold off until every fetch has returned and the pipeline has emptied.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Set sizes, fill the used source area, then fetch corners and send random items.
   task automatic run_phase(input int unsigned sw_reg, input int unsigned sh_reg,
                            input int unsigned dw_reg, input int unsigned dh_reg,
                            input int nfetch);
      int unsigned sw, sh, dw, dh, pick;
      drain();
      write_reg(CSR_SRC_WIDTH, sw_reg);
      write_reg(CSR_SRC_HEIGHT, sh_reg);
      write_reg(CSR_DST_WIDTH, dw_reg);
      write_reg(CSR_DST_HEIGHT, dh_reg);
      sw = (sw_reg[8:0] == 0) ? 1 : (sw_reg[8:0] > 256 ? 256 : sw_reg[8:0]);
      sh = (sh_reg[8:0] == 0) ? 1 : (sh_reg[8:0] > 256 ? 256 : sh_reg[8:0]);
      dw = dw_reg[12:0] > 4096 ? 4096 : dw_reg[12:0];
      dh = dh_reg[12:0] > 4096 ? 4096 : dh_reg[12:0];
      for (int unsigned y = 0; y < sh; y++)
         for (int unsigned x = 0; x < sw; x++)
            send_item(ACT_WRITE, x, y, $urandom());
      if (dw > 0 && dh > 0) begin
         send_item(ACT_FETCH, 0, 0, 0);
         send_item(ACT_FETCH, dw - 1, dh - 1, 0);
         send_item(ACT_FETCH, dw - 1, 0, 0);
         send_item(ACT_FETCH, 0, dh - 1, 0);
      end
      send_item(ACT_FETCH, dw, 0, 0);
      send_item(ACT_FETCH, 0, dh, 0);
      for (int i = 0; i < nfetch; i++) begin
         pick = $urandom_range(99);
         if (pick < 10)
            send_item(ACT_WRITE, $urandom(), $urandom(), $urandom());
         else if (pick < 25 || dw == 0 || dh == 0)
            send_item(ACT_FETCH, $urandom(), $urandom(), $urandom());
         else
            send_item(ACT_FETCH, $urandom_range(dw - 1), $urandom_range(dh - 1),
                      $urandom());
      end
   endtask

   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

   initial begin
      int unsigned sw, sh, dw, dh;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_SRC_WIDTH;
      csr_wdata      = '0;
      req.valid      = 1'b0;
      req.action     = ACT_WRITE;
      req.pos_x      = '0;
      req.pos_y      = '0;
      req.in_red     = '0;
      req.in_green   = '0;
      req.in_blue    = '0;
      item_count     = 0;
      send_idle_pct  = 21;
      recv_stall_pct = 49;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: writes at and past the storage edge, fetches outside the frame.
      send_item(ACT_WRITE, 0, 0, 'hFFFFFF);
      send_item(ACT_WRITE, 255, 255, 'h000000);
      send_item(ACT_WRITE, 'hFFF, 'hFFF, 'hA5A5A5);
      send_item(ACT_WRITE, 256, 3, 'h5A5A5A);
      send_item(ACT_FETCH, 256, 0, 0);
      send_item(ACT_FETCH, 0, 'hFFF, 0);
      send_item(ACT_FETCH, 'hFFF, 'hFFF, 'hFFFFFF);

      // Extreme sizes, then random ones until enough items have gone out.
      run_phase(1, 1, 1, 1, 20);
      run_phase(0, 0, 4096, 4096, 40);
      run_phase(256, 2, 4096, 3, 40);
      run_phase(2, 128, 3, 8191, 40);
      run_phase(511, 1, 0, 5, 20);
      run_phase(3, 5, 8191, 0, 20);
      while (item_count < 1250) begin
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 12);
         dw = ($urandom_range(9) < 8) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
         dh = ($urandom_range(9) < 8) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
         run_phase(sw, sh, dw, dh, 60);
      end

      drain();
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// File: bilinear_image_scaler_top.f
hdl/bis_pkg.sv
hdl/bis_if.sv
hdl/bis_step_div.sv
hdl/bis_front.sv
hdl/bis_queue.sv
hdl/bis_back.sv
hdl/bilinear_image_scaler_top.sv
tb/scaler_checker.sv
tb/tb.sv
